@@ hdl/fovp_pkg.sv @@
package fovp_pkg;

    // Number of axes carried by one word; fixed by the port list.
    localparam int AXES    = 3;

    // Field widths.
    localparam int COORD_W = 32;
    localparam int ERR_W   = COORD_W + 1;
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + $clog2(AXES);
    localparam int LEN_W   = (SUM_W + 1) / 2;
    localparam int FRAC    = 16;

    // Configuration register widths.
    localparam int DEC_W   = 16;
    localparam int DR_W    = 32;
    localparam int MS_W    = 31;
    localparam int CG_W    = 24;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Speed planning widths.
    localparam int PA_W    = DR_W + LEN_W;
    localparam int SPA_W   = PA_W - FRAC;
    localparam int PB1_W   = DEC_W + LEN_W;
    localparam int PB2_W   = DEC_W + 1 + MS_W;
    localparam int BLEND_W = ((PB1_W > PB2_W) ? PB1_W : PB2_W) + 1;
    localparam int SPD_W   = BLEND_W - FRAC;
    localparam int CMP_W   = (SPA_W > SPD_W) ? SPA_W : SPD_W;

    // Command scaling widths.
    localparam int GS_W    = CG_W + SPD_W;
    localparam int SPLIT   = 32;
    localparam int PPL_W   = SPLIT + MAG_W;
    localparam int PPH_W   = GS_W - SPLIT + MAG_W;
    localparam int NUM_W   = GS_W + MAG_W;
    localparam int DEN_W   = LEN_W + FRAC;
    localparam int QUO_W   = 33;

    // Pipeline depth from the accepting edge to the edge that takes the result.
    localparam int SQRT_LAT = LEN_W;
    localparam int DIV_LAT  = QUO_W + 1;
    localparam int LATENCY  = 3 + SQRT_LAT + 5 + DIV_LAT + 1;

    // Reset values of the configuration registers.
    localparam logic [DEC_W-1:0] DECAY_RESET = 16'd59310;
    localparam logic [DR_W-1:0]  DRATE_RESET = 32'd5636096;
    localparam logic [MS_W-1:0]  MAXSP_RESET = 31'd6554;
    localparam logic [CG_W-1:0]  GAIN_RESET  = 24'd32768;

    // One in Q0.16 with a spare bit.
    localparam logic [DEC_W:0]   ONE_Q16     = 17'h10000;

    // Saturation limits.
    localparam logic [QUO_W-1:0]   SAT_MAG = 33'h0_8000_0000;
    localparam logic [COORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY = 2'd0,
        CFG_DRATE = 2'd1,
        CFG_MAXSP = 2'd2,
        CFG_GAIN  = 2'd3
    } cfg_idx_t;

endpackage

@@ hdl/fovp_sqrt.sv @@
module fovp_sqrt #(
    parameter int IN_W   = 66,
    parameter int SIDE_W = 1,
    parameter int OUT_W  = (IN_W + 1) / 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [IN_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [OUT_W-1:0]  root,
    output logic [SIDE_W-1:0] out_side
);

    // One result bit per stage; the remainder holds radicand minus root squared.
    localparam int TW = 2 * OUT_W + 1;

    logic              vld_reg  [OUT_W];
    logic [TW-1:0]     rem_reg  [OUT_W];
    logic [OUT_W-1:0]  root_reg [OUT_W];
    logic [SIDE_W-1:0] side_reg [OUT_W];

    for (genvar g = 0; g < OUT_W; g++) begin : g_stage
        localparam int K = OUT_W - 1 - g;

        logic              vld_in;
        logic [TW-1:0]     rem_in;
        logic [OUT_W-1:0]  root_in;
        logic [SIDE_W-1:0] side_in;
        logic [TW-1:0]     trial;
        logic              take;
        logic [TW-1:0]     rem_next;
        logic [OUT_W-1:0]  root_next;

        if (g == 0) begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = TW'(radicand);
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign vld_in  = vld_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        // Lower root bits are still zero, so the two terms do not overlap.
        assign trial     = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
        assign take      = rem_in >= trial;
        assign rem_next  = take ? rem_in - trial : rem_in;
        assign root_next = take ? root_in | (OUT_W'(1) << K) : root_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else
            begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= rem_next;
            root_reg[g] <= root_next;
            side_reg[g] <= side_in;
        end
    end

    assign out_vld  = vld_reg[OUT_W-1];
    assign root     = root_reg[OUT_W-1];
    assign out_side = side_reg[OUT_W-1];

endmodule

@@ hdl/fovp_div.sv @@
module fovp_div #(
    parameter int NUM_W  = 90,
    parameter int DEN_W  = 49,
    parameter int QUO_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [QUO_W-1:0]  quo,
    output logic              big,
    output logic [SIDE_W-1:0] out_side
);

    // The first stage flags quotients that do not fit; the rest find one bit each.
    localparam int HI_W = NUM_W - QUO_W;

    logic              vld_reg  [QUO_W+1];
    logic [DEN_W-1:0]  rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]  low_reg  [QUO_W+1];
    logic [QUO_W-1:0]  quo_reg  [QUO_W+1];
    logic [DEN_W-1:0]  den_reg  [QUO_W+1];
    logic              big_reg  [QUO_W+1];
    logic [SIDE_W-1:0] side_reg [QUO_W+1];

    logic [HI_W-1:0]   num_hi;
    logic              big_next;

    assign num_hi   = num[NUM_W-1:QUO_W];
    assign big_next = num_hi >= HI_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num_hi[DEN_W-1:0];
        low_reg[0]  <= num[QUO_W-1:0];
        quo_reg[0]  <= '0;
        den_reg[0]  <= den;
        big_reg[0]  <= big_next;
        side_reg[0] <= in_side;
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_step
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;
        logic [DEN_W-1:0] rem_next;

        assign trial    = {rem_reg[g], low_reg[g][QUO_W-1]};
        assign diff     = trial - {1'b0, den_reg[g]};
        assign take     = trial >= {1'b0, den_reg[g]};
        assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g+1] <= 1'b0;
            end
            else
            begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g+1]  <= rem_next;
            low_reg[g+1]  <= {low_reg[g][QUO_W-2:0], 1'b0};
            quo_reg[g+1]  <= {quo_reg[g][QUO_W-2:0], take};
            den_reg[g+1]  <= den_reg[g];
            big_reg[g+1]  <= big_reg[g];
            side_reg[g+1] <= side_reg[g];
        end
    end

    assign out_vld  = vld_reg[QUO_W];
    assign quo      = quo_reg[QUO_W];
    assign big      = big_reg[QUO_W];
    assign out_side = side_reg[QUO_W];

endmodule

@@ hdl/first_order_velocity_planner_unit.sv @@
// Each word accepted at a clock edge gives one result, marked by done.
// Throughput: one word per clock while busy is low; the 33-stage square root and the 34-stage divider set depth.
// Reset: rst_n clears all valid bits and restores the configuration registers to defaults.
// busy is high only in the first cycle after reset; otherwise a word may start every cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
module first_order_velocity_planner_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [fovp_pkg::COORD_W-1:0] target_x,
    input  logic signed [fovp_pkg::COORD_W-1:0] target_y,
    input  logic signed [fovp_pkg::COORD_W-1:0] target_z,
    input  logic signed [fovp_pkg::COORD_W-1:0] actual_x,
    input  logic signed [fovp_pkg::COORD_W-1:0] actual_y,
    input  logic signed [fovp_pkg::COORD_W-1:0] actual_z,
    input  logic signed [fovp_pkg::COORD_W-1:0] velocity_x,
    input  logic signed [fovp_pkg::COORD_W-1:0] velocity_y,
    input  logic signed [fovp_pkg::COORD_W-1:0] velocity_z,
    input  logic                                cfg_we,
    input  logic [fovp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fovp_pkg::CFG_W-1:0]          cfg_data,
    output logic                                done,
    output logic signed [fovp_pkg::COORD_W-1:0] command_x,
    output logic signed [fovp_pkg::COORD_W-1:0] command_y,
    output logic signed [fovp_pkg::COORD_W-1:0] command_z,
    output logic                                at_target
);

    // Pipeline outline:
    //   s1  error vector and magnitudes of error and velocity per axis
    //   s2  squares per axis
    //   s3  sums of squares
    //   sq  two square-root pipelines in parallel, one bit per stage (error and velocity length)
    //   s4  distance_rate*L, decay*V and (1-decay)*max_speed
    //   s5  planned speed as the smaller of the two limits
    //   s6  gain times speed
    //   s7  gain*speed*|e| as two partial products per axis
    //   s8  sum of the partial products and the divisor L<<16
    //   dv  one divider per axis, one quotient bit per stage, with overflow flag
    //   out saturation, sign and the zero-length case
    // Configuration is read straight from its registers; the user must change it only while idle (unchecked).

    localparam int AXES    = fovp_pkg::AXES;
    localparam int COORD_W = fovp_pkg::COORD_W;
    localparam int ERR_W   = fovp_pkg::ERR_W;
    localparam int MAG_W   = fovp_pkg::MAG_W;
    localparam int SQ_W    = fovp_pkg::SQ_W;
    localparam int SUM_W   = fovp_pkg::SUM_W;
    localparam int LEN_W   = fovp_pkg::LEN_W;
    localparam int FRAC    = fovp_pkg::FRAC;
    localparam int DEC_W   = fovp_pkg::DEC_W;
    localparam int DR_W    = fovp_pkg::DR_W;
    localparam int MS_W    = fovp_pkg::MS_W;
    localparam int CG_W    = fovp_pkg::CG_W;
    localparam int PA_W    = fovp_pkg::PA_W;
    localparam int SPA_W   = fovp_pkg::SPA_W;
    localparam int PB1_W   = fovp_pkg::PB1_W;
    localparam int PB2_W   = fovp_pkg::PB2_W;
    localparam int BLEND_W = fovp_pkg::BLEND_W;
    localparam int SPD_W   = fovp_pkg::SPD_W;
    localparam int CMP_W   = fovp_pkg::CMP_W;
    localparam int GS_W    = fovp_pkg::GS_W;
    localparam int SPLIT   = fovp_pkg::SPLIT;
    localparam int PPL_W   = fovp_pkg::PPL_W;
    localparam int PPH_W   = fovp_pkg::PPH_W;
    localparam int NUM_W   = fovp_pkg::NUM_W;
    localparam int DEN_W   = fovp_pkg::DEN_W;
    localparam int QUO_W   = fovp_pkg::QUO_W;

    // Configuration registers.
    logic [DEC_W-1:0] decay_reg;
    logic [DR_W-1:0]  drate_reg;
    logic [MS_W-1:0]  maxsp_reg;
    logic [CG_W-1:0]  gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= fovp_pkg::DECAY_RESET;
            drate_reg <= fovp_pkg::DRATE_RESET;
            maxsp_reg <= fovp_pkg::MAXSP_RESET;
            gain_reg  <= fovp_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fovp_pkg::CFG_DECAY: decay_reg <= cfg_data[DEC_W-1:0];
                fovp_pkg::CFG_DRATE: drate_reg <= cfg_data[DR_W-1:0];
                fovp_pkg::CFG_MAXSP: maxsp_reg <= cfg_data[MS_W-1:0];
                fovp_pkg::CFG_GAIN:  gain_reg  <= cfg_data[CG_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline takes a word every cycle; busy only covers the cycle after reset.
    logic busy_reg;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // Input gathering and stage s1.
    logic signed [COORD_W-1:0] tgt [AXES];
    logic signed [COORD_W-1:0] act [AXES];
    logic signed [COORD_W-1:0] vel [AXES];

    assign tgt[0] = target_x;
    assign tgt[1] = target_y;
    assign tgt[2] = target_z;
    assign act[0] = actual_x;
    assign act[1] = actual_y;
    assign act[2] = actual_z;
    assign vel[0] = velocity_x;
    assign vel[1] = velocity_y;
    assign vel[2] = velocity_z;

    logic signed [ERR_W-1:0] err      [AXES];
    logic signed [ERR_W-1:0] err_neg  [AXES];
    logic [COORD_W-1:0]      vel_neg  [AXES];
    logic [MAG_W-1:0]        em_next  [AXES];
    logic [MAG_W-1:0]        vm_next  [AXES];
    logic [AXES-1:0]         neg_next;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            err[i]      = ERR_W'(tgt[i]) - ERR_W'(act[i]);
            err_neg[i]  = -err[i];
            vel_neg[i]  = COORD_W'(0) - vel[i];
            em_next[i]  = err[i][ERR_W-1] ? err_neg[i][MAG_W-1:0] : err[i][MAG_W-1:0];
            vm_next[i]  = vel[i][COORD_W-1] ? vel_neg[i] : vel[i];
            neg_next[i] = err[i][ERR_W-1];
        end
    end

    logic             s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic             s4_vld_reg, s5_vld_reg, s6_vld_reg, s7_vld_reg, s8_vld_reg;
    logic [MAG_W-1:0] em_s1_reg  [AXES];
    logic [MAG_W-1:0] vm_s1_reg  [AXES];
    logic [AXES-1:0]  neg_s1_reg;

    // Stage s2: squares.
    logic [SQ_W-1:0]  esq_reg    [AXES];
    logic [SQ_W-1:0]  vsq_reg    [AXES];
    logic [MAG_W-1:0] em_s2_reg  [AXES];
    logic [AXES-1:0]  neg_s2_reg;

    // Stage s3: sums of squares.
    logic [SUM_W-1:0] se_next, sv_next;
    logic [SUM_W-1:0] se_reg, sv_reg;
    logic [MAG_W-1:0] em_s3_reg  [AXES];
    logic [AXES-1:0]  neg_s3_reg;

    always_comb
    begin
        se_next = '0;
        sv_next = '0;
        for (int i = 0; i < AXES; i++)
        begin
            se_next = se_next + SUM_W'(esq_reg[i]);
            sv_next = sv_next + SUM_W'(vsq_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < AXES; i++)
        begin
            em_s1_reg[i] <= em_next[i];
            vm_s1_reg[i] <= vm_next[i];
            esq_reg[i]   <= SQ_W'(em_s1_reg[i]) * SQ_W'(em_s1_reg[i]);
            vsq_reg[i]   <= SQ_W'(vm_s1_reg[i]) * SQ_W'(vm_s1_reg[i]);
            em_s2_reg[i] <= em_s1_reg[i];
            em_s3_reg[i] <= em_s2_reg[i];
        end
        neg_s1_reg <= neg_next;
        neg_s2_reg <= neg_s1_reg;
        neg_s3_reg <= neg_s2_reg;
        se_reg     <= se_next;
        sv_reg     <= sv_next;
    end

    // Square roots. The error length pipeline carries the error magnitudes,
    // the velocity length pipeline carries the error signs.
    logic [AXES*MAG_W-1:0] em_pack;
    logic [AXES*MAG_W-1:0] em_pack_sq;
    logic [MAG_W-1:0]      em_sq [AXES];
    logic [AXES-1:0]       neg_sq;
    logic [LEN_W-1:0]      len_sq, vlen_sq;
    logic                  len_vld, vlen_vld;

    for (genvar i = 0; i < AXES; i++) begin : g_pack
        assign em_pack[i*MAG_W +: MAG_W] = em_s3_reg[i];
        assign em_sq[i]                  = em_pack_sq[i*MAG_W +: MAG_W];
    end

    fovp_sqrt #(
        .IN_W   (SUM_W),
        .SIDE_W (AXES*MAG_W),
        .OUT_W  (LEN_W)
    ) u_sqrt_err (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s3_vld_reg),
        .radicand (se_reg),
        .in_side  (em_pack),
        .out_vld  (len_vld),
        .root     (len_sq),
        .out_side (em_pack_sq)
    );

    fovp_sqrt #(
        .IN_W   (SUM_W),
        .SIDE_W (AXES),
        .OUT_W  (LEN_W)
    ) u_sqrt_vel (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s3_vld_reg),
        .radicand (sv_reg),
        .in_side  (neg_s3_reg),
        .out_vld  (vlen_vld),
        .root     (vlen_sq),
        .out_side (neg_sq)
    );

    // Stage s4: the three products of the speed limits.
    logic [PA_W-1:0]  pa_reg;
    logic [PB1_W-1:0] pb1_reg;
    logic [PB2_W-1:0] pb2_reg;
    logic [DEC_W:0]   decay_rest;
    logic [LEN_W-1:0] len_s4_reg, len_s5_reg, len_s6_reg, len_s7_reg;
    logic [MAG_W-1:0] em_s4_reg  [AXES];
    logic [MAG_W-1:0] em_s5_reg  [AXES];
    logic [MAG_W-1:0] em_s6_reg  [AXES];
    logic [AXES-1:0]  neg_s4_reg, neg_s5_reg, neg_s6_reg, neg_s7_reg, neg_s8_reg;
    logic             zero_s4_reg, zero_s5_reg, zero_s6_reg, zero_s7_reg, zero_s8_reg;

    assign decay_rest = fovp_pkg::ONE_Q16 - (DEC_W+1)'(decay_reg);

    // Stage s5: the planned speed.
    logic [BLEND_W-1:0] blend;
    logic [SPA_W-1:0]   spa;
    logic [SPD_W-1:0]   spb;
    logic [SPD_W-1:0]   speed_next;
    logic [SPD_W-1:0]   speed_reg;

    assign blend      = BLEND_W'(pb1_reg) + BLEND_W'(pb2_reg);
    assign spa        = pa_reg[PA_W-1:FRAC];
    assign spb        = blend[BLEND_W-1:FRAC];
    assign speed_next = (CMP_W'(spa) < CMP_W'(spb)) ? SPD_W'(spa) : spb;

    // Stages s6 to s8: gain, partial products and their sum.
    logic [GS_W-1:0]  gs_reg;
    logic [PPL_W-1:0] pp_lo_reg [AXES];
    logic [PPH_W-1:0] pp_hi_reg [AXES];
    logic [NUM_W-1:0] num_reg   [AXES];
    logic [DEN_W-1:0] den_reg;

    always_ff @(posedge clk)
    begin
        pa_reg      <= PA_W'(drate_reg) * PA_W'(len_sq);
        pb1_reg     <= PB1_W'(decay_reg) * PB1_W'(vlen_sq);
        pb2_reg     <= PB2_W'(decay_rest) * PB2_W'(maxsp_reg);
        zero_s4_reg <= len_sq == '0;
        len_s4_reg  <= len_sq;
        neg_s4_reg  <= neg_sq;

        speed_reg   <= speed_next;
        zero_s5_reg <= zero_s4_reg;
        len_s5_reg  <= len_s4_reg;
        neg_s5_reg  <= neg_s4_reg;

        gs_reg      <= GS_W'(gain_reg) * GS_W'(speed_reg);
        zero_s6_reg <= zero_s5_reg;
        len_s6_reg  <= len_s5_reg;
        neg_s6_reg  <= neg_s5_reg;

        zero_s7_reg <= zero_s6_reg;
        len_s7_reg  <= len_s6_reg;
        neg_s7_reg  <= neg_s6_reg;

        den_reg     <= {len_s7_reg, FRAC'(0)};
        zero_s8_reg <= zero_s7_reg;
        neg_s8_reg  <= neg_s7_reg;

        for (int i = 0; i < AXES; i++)
        begin
            em_s4_reg[i] <= em_sq[i];
            em_s5_reg[i] <= em_s4_reg[i];
            em_s6_reg[i] <= em_s5_reg[i];
            pp_lo_reg[i] <= PPL_W'(gs_reg[SPLIT-1:0]) * PPL_W'(em_s6_reg[i]);
            pp_hi_reg[i] <= PPH_W'(gs_reg[GS_W-1:SPLIT]) * PPH_W'(em_s6_reg[i]);
            num_reg[i]   <= (NUM_W'(pp_hi_reg[i]) << SPLIT) + NUM_W'(pp_lo_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= len_vld && vlen_vld;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
        end
    end

    // One divider per axis. The first also carries the zero-length flag.
    logic             div_vld;
    logic             div_zero;
    logic [QUO_W-1:0] div_q   [AXES];
    logic [AXES-1:0]  div_big;
    logic [AXES-1:0]  div_neg;

    for (genvar i = 0; i < AXES; i++) begin : g_div
        if (i == 0) begin : g_lead
            logic [1:0] side_out;

            fovp_div #(
                .NUM_W  (NUM_W),
                .DEN_W  (DEN_W),
                .QUO_W  (QUO_W),
                .SIDE_W (2)
            ) u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_vld   (s8_vld_reg),
                .num      (num_reg[i]),
                .den      (den_reg),
                .in_side  ({zero_s8_reg, neg_s8_reg[i]}),
                .out_vld  (div_vld),
                .quo      (div_q[i]),
                .big      (div_big[i]),
                .out_side (side_out)
            );

            assign div_zero   = side_out[1];
            assign div_neg[i] = side_out[0];
        end else begin : g_other
            fovp_div #(
                .NUM_W  (NUM_W),
                .DEN_W  (DEN_W),
                .QUO_W  (QUO_W),
                .SIDE_W (1)
            ) u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_vld   (s8_vld_reg),
                .num      (num_reg[i]),
                .den      (den_reg),
                .in_side  (neg_s8_reg[i]),
                .out_vld  (),
                .quo      (div_q[i]),
                .big      (div_big[i]),
                .out_side (div_neg[i])
            );
        end
    end

    // Output stage: clamp the magnitude, apply the sign, and force a zero
    // command when the error length is zero.
    logic [QUO_W-1:0]   mag_sat  [AXES];
    logic [COORD_W-1:0] cmd_next [AXES];
    logic [COORD_W-1:0] cmd_reg  [AXES];
    logic               at_target_reg;
    logic               done_reg;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            mag_sat[i] = (div_big[i] || div_q[i] > fovp_pkg::SAT_MAG) ?
                         fovp_pkg::SAT_MAG : div_q[i];
            if (div_zero)
            begin
                cmd_next[i] = '0;
            end
            else if (div_neg[i])
            begin
                cmd_next[i] = COORD_W'(0) - mag_sat[i][COORD_W-1:0];
            end
            else if (mag_sat[i] > QUO_W'(fovp_pkg::POS_MAX))
            begin
                cmd_next[i] = fovp_pkg::POS_MAX;
            end
            else
            begin
                cmd_next[i] = mag_sat[i][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < AXES; i++)
        begin
            cmd_reg[i] <= cmd_next[i];
        end
        at_target_reg <= div_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld;
        end
    end

    assign done      = done_reg;
    assign command_x = cmd_reg[0];
    assign command_y = cmd_reg[1];
    assign command_z = cmd_reg[2];
    assign at_target = at_target_reg;

endmodule

@@ hdl/fovp_checker.sv @@
module fovp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic signed [fovp_pkg::COORD_W-1:0] target_x,
    input logic signed [fovp_pkg::COORD_W-1:0] target_y,
    input logic signed [fovp_pkg::COORD_W-1:0] target_z,
    input logic signed [fovp_pkg::COORD_W-1:0] actual_x,
    input logic signed [fovp_pkg::COORD_W-1:0] actual_y,
    input logic signed [fovp_pkg::COORD_W-1:0] actual_z,
    input logic signed [fovp_pkg::COORD_W-1:0] velocity_x,
    input logic signed [fovp_pkg::COORD_W-1:0] velocity_y,
    input logic signed [fovp_pkg::COORD_W-1:0] velocity_z,
    input logic                                cfg_we,
    input logic [fovp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [fovp_pkg::CFG_W-1:0]          cfg_data,
    input logic                                done,
    input logic signed [fovp_pkg::COORD_W-1:0] command_x,
    input logic signed [fovp_pkg::COORD_W-1:0] command_y,
    input logic signed [fovp_pkg::COORD_W-1:0] command_z,
    input logic                                at_target
);

    localparam int LAT = fovp_pkg::LATENCY;

    // Every result word traces back to an accepted input word.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result word without a matching input word");

    // At the target every command axis is zero.
    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && at_target |-> command_x == 0 && command_y == 0 && command_z == 0)
        else $error("non-zero command while at target");

    // at_target reflects whether the target equalled the position of that word.
    a_target_match: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> at_target == $past(target_x == actual_x && target_y == actual_y &&
                                    target_z == actual_z, LAT))
        else $error("at_target does not match the input word");

    // A non-zero x command points the way of the x error.
    a_sign_x: assert property (@(posedge clk) disable iff (!rst_n)
        done && !at_target && command_x != 0 |->
            command_x[fovp_pkg::COORD_W-1] == $past(target_x < actual_x, LAT))
        else $error("x command has the wrong sign");

endmodule

bind first_order_velocity_planner_unit fovp_checker u_fovp_checker (.*);
